FILE: design/pfb_pkg.sv
// Shared types, constants and the CRC byte update for the position frame builder.
package pfb_pkg;

  // Configuration port widths and register indexes.
  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 8;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_MARKER = 8'd0,
    CFG_END_MARKER   = 8'd1
  } cfg_idx_t;

  // Marker reset values.
  localparam logic [7:0] StartMarkerRst = 8'hAA;
  localparam logic [7:0] EndMarkerRst   = 8'h55;

  // CRC-16 AUG-CCITT parameters.
  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [15:0] CrcInit = 16'h1D0F;

  // Default depth of the record queue between front and back.
  localparam int QueueDepthDflt = 2;

  // One input record.
  typedef struct packed {
    logic [7:0]         status_flag;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] heading_deg;
  } rec_t;

  // Marker bytes handed from the register block to the serializer.
  typedef struct packed {
    logic [7:0] start_marker;
    logic [7:0] end_marker;
  } markers_t;

  // Byte position within the outgoing frame.
  typedef enum logic [3:0] {
    POS_START,
    POS_FLAG,
    POS_XH,
    POS_XL,
    POS_YH,
    POS_YL,
    POS_HDG_H,
    POS_HDG_L,
    POS_CRC_H,
    POS_CRC_L,
    POS_END
  } frame_pos_t;

  // Fold one byte into the running CRC, MSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: design/pfb_intf.sv
// Channel interfaces: record input, frame byte output and configuration writes.
interface pfb_rec_if;
  import pfb_pkg::*;
  logic               valid;
  logic               ready;
  logic [7:0]         status_flag;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] heading_deg;

  modport source (output valid, status_flag, pos_x, pos_y, heading_deg, input ready);
  modport sink   (input valid, status_flag, pos_x, pos_y, heading_deg, output ready);
endinterface

interface pfb_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_last;

  modport source (output valid, frame_byte, frame_last, input ready);
  modport sink   (input valid, frame_byte, frame_last, output ready);
endinterface

interface pfb_cfg_if;
  import pfb_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/position_frame_builder_crc16_core.sv
// A record accepted by the serializer is loaded into its record register, and the first
// frame byte then goes into the output register. Throughput: one frame byte per cycle
// while the output accepts, set by the single-byte output register of the serializer;
// a record queue lets input continue while a frame is still going out.
// Reset (synchronous, active low) empties the queue, idles the serializer and
// restores the start and end markers to 0xAA and 0x55.
module position_frame_builder_crc16_core #(
  parameter int QueueDepth = pfb_pkg::QueueDepthDflt
) (
  input  logic       clk,
  input  logic       rst_n,
  pfb_rec_if.sink    in_rec,
  pfb_byte_if.source out_frame,
  pfb_cfg_if.sink    cfg_wr
);
  import pfb_pkg::*;

  logic     q_valid;
  logic     q_ready;
  rec_t     q_data;
  markers_t markers;

  // Marker registers.
  pfb_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_wr),
    .markers (markers)
  );

  // Record intake and queue.
  pfb_front #(
    .QueueDepth (QueueDepth)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_rec  (in_rec),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_data  (q_data)
  );

  // Frame serializer with running CRC.
  pfb_serializer u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_data),
    .markers   (markers),
    .out_frame (out_frame)
  );
endmodule

FILE: design/pfb_cfg_regs.sv
// Configuration register block holding the start and end marker bytes.
module pfb_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  pfb_cfg_if.sink           cfg,
  output pfb_pkg::markers_t markers
);
  import pfb_pkg::*;

  logic [7:0] start_r;
  logic [7:0] end_r;

  // Writes are always taken; unknown indexes are dropped.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= StartMarkerRst;
      end_r   <= EndMarkerRst;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_START_MARKER: start_r <= cfg.data;
        CFG_END_MARKER:   end_r   <= cfg.data;
        default: ;
      endcase
    end
  end

  assign markers.start_marker = start_r;
  assign markers.end_marker   = end_r;
endmodule

FILE: design/pfb_front.sv
// Front end: accepts records and holds them in a short queue for the serializer.
module pfb_front #(
  parameter int QueueDepth = pfb_pkg::QueueDepthDflt
) (
  input  logic          clk,
  input  logic          rst_n,
  pfb_rec_if.sink       in_rec,
  output logic          q_valid,
  input  logic          q_ready,
  output pfb_pkg::rec_t q_data
);
  import pfb_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

  rec_t            mem_r [QueueDepth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            push, pop;
  rec_t            in_word;

  // Pack the incoming fields into one record.
  assign in_word.status_flag = in_rec.status_flag;
  assign in_word.pos_x       = in_rec.pos_x;
  assign in_word.pos_y       = in_rec.pos_y;
  assign in_word.heading_deg = in_rec.heading_deg;

  assign in_rec.ready = (cnt_r != FullCnt);
  assign push         = in_rec.valid && in_rec.ready;
  assign q_valid      = (cnt_r != '0);
  assign pop          = q_valid && q_ready;
  assign q_data       = mem_r[rd_ptr_r];

  // Pointer and fill count updates, wrapping at the queue depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_word;
    end
  end
endmodule

FILE: design/pfb_serializer.sv
// Back end: walks one record through the eleven frame bytes, folding the CRC in as it goes.
module pfb_serializer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_ready,
  input  pfb_pkg::rec_t     q_data,
  input  pfb_pkg::markers_t markers,
  pfb_byte_if.source        out_frame
);
  import pfb_pkg::*;

  rec_t       rec_r, rec_nxt;
  frame_pos_t pos_r, pos_nxt;
  logic       busy_r, busy_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_last_r, out_last_nxt;

  logic       adv, emit, pop, crc_upd;
  logic [7:0] sel_byte;

  // The output slot can take a byte when empty or being drained.
  assign adv     = !out_valid_r || out_frame.ready;
  assign emit    = busy_r && adv;
  assign q_ready = !busy_r || (adv && (pos_r == POS_END));
  assign pop     = q_valid && q_ready;

  // Next frame position and busy flag.
  always_comb begin
    pos_nxt  = pos_r;
    busy_nxt = busy_r;
    rec_nxt  = rec_r;
    if (emit) begin
      unique case (pos_r)
        POS_START: pos_nxt = POS_FLAG;
        POS_FLAG:  pos_nxt = POS_XH;
        POS_XH:    pos_nxt = POS_XL;
        POS_XL:    pos_nxt = POS_YH;
        POS_YH:    pos_nxt = POS_YL;
        POS_YL:    pos_nxt = POS_HDG_H;
        POS_HDG_H: pos_nxt = POS_HDG_L;
        POS_HDG_L: pos_nxt = POS_CRC_H;
        POS_CRC_H: pos_nxt = POS_CRC_L;
        POS_CRC_L: pos_nxt = POS_END;
        POS_END:   pos_nxt = POS_START;
        default:   pos_nxt = POS_START;
      endcase
      if (pos_r == POS_END) begin
        busy_nxt = 1'b0;
      end
    end
    if (pop) begin
      pos_nxt  = POS_START;
      busy_nxt = 1'b1;
      rec_nxt  = q_data;
    end
  end

  // Byte selection, CRC update and output register contents.
  always_comb begin
    crc_upd = 1'b0;
    unique case (pos_r)
      POS_START: sel_byte = markers.start_marker;
      POS_FLAG:  sel_byte = rec_r.status_flag;
      POS_XH:    sel_byte = rec_r.pos_x[15:8];
      POS_XL:    sel_byte = rec_r.pos_x[7:0];
      POS_YH:    sel_byte = rec_r.pos_y[15:8];
      POS_YL:    sel_byte = rec_r.pos_y[7:0];
      POS_HDG_H: sel_byte = rec_r.heading_deg[15:8];
      POS_HDG_L: sel_byte = rec_r.heading_deg[7:0];
      POS_CRC_H: sel_byte = crc_r[15:8];
      POS_CRC_L: sel_byte = crc_r[7:0];
      POS_END:   sel_byte = markers.end_marker;
      default:   sel_byte = markers.end_marker;
    endcase

    unique case (pos_r) inside
      POS_FLAG, POS_XH, POS_XL, POS_YH, POS_YL, POS_HDG_H, POS_HDG_L: crc_upd = 1'b1;
      default: crc_upd = 1'b0;
    endcase

    crc_nxt = crc_r;
    if (emit && crc_upd) begin
      crc_nxt = crc_byte(crc_r, sel_byte);
    end
    if (pop) begin
      crc_nxt = CrcInit;
    end

    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = sel_byte;
      out_last_nxt  = (pos_r == POS_END);
    end else if (out_frame.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= POS_START;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    rec_r      <= rec_nxt;
    crc_r      <= crc_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_frame.valid      = out_valid_r;
  assign out_frame.frame_byte = out_byte_r;
  assign out_frame.frame_last = out_last_r;
endmodule
